@@ rtl/core/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte functions of the AES block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int STATE_COLUMNS   = 4;
    localparam int KEY_STORE_WORDS = 60;
    localparam int KEY_ADDR_W      = $clog2(KEY_STORE_WORDS);
    localparam int KEY_ROUNDS      = KEY_STORE_WORDS / STATE_COLUMNS;
    localparam int RK_ADDR_W       = $clog2(KEY_ROUNDS);
    localparam int FIFO_DEPTH      = 2;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_128 = 2'd0,
        MODE_192 = 2'd1,
        MODE_256 = 2'd2,
        MODE_SAT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ROUND = 2'd1,
        ST_DONE  = 2'd2
    } eng_state_t;

    typedef struct packed {
        logic                  load;
        logic                  decrypt;
        logic [KEY_ADDR_W-1:0] key_addr;
        logic [31:0]           key_data;
        logic [127:0]          block;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] b [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m1 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] r  [4];
        for (int i = 0; i < 4; i++)
        begin
            b[i]  = c[31-8*i -: 8];
            x2[i] = xt(b[i]);
            x4[i] = xt(x2[i]);
            x8[i] = xt(x4[i]);
            if (inv)
            begin
                m1[i] = x8[i] ^ x4[i] ^ x2[i];
                m2[i] = x8[i] ^ x2[i] ^ b[i];
                m3[i] = x8[i] ^ x4[i] ^ b[i];
            end
            else
            begin
                m1[i] = x2[i];
                m2[i] = x2[i] ^ b[i];
                m3[i] = b[i];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (inv)
            begin
                r[i] = m1[i] ^ m2[(i+1)%4] ^ m3[(i+2)%4] ^ (x8[(i+3)%4] ^ b[(i+3)%4]);
            end
            else
            begin
                r[i] = m1[i] ^ m2[(i+1)%4] ^ b[(i+2)%4] ^ b[(i+3)%4];
            end
        end
        return {r[0], r[1], r[2], r[3]};
    endfunction

endpackage

@@ rtl/core/aes_front.sv @@
// ----------------------------------------------------------------------------
// aes_front
// Classifies input transfers: key loads and blocks enter a short job queue,
// in order, that feeds the round engine; other items are dropped.
// ----------------------------------------------------------------------------
module aes_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        cmd,
    input  logic [5:0]        key_word_index,
    input  logic [31:0]       key_word,
    input  logic [63:0]       block_hi,
    input  logic [63:0]       block_lo,
    output logic              job_valid,
    output aes_pkg::job_t     job,
    input  logic              job_take
);
    import aes_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    job_t             fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [PTR_W:0]   cnt_reg;
    logic             acc, is_blk, is_load, enq;

    assign full    = (cnt_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign acc     = push && !full;
    assign is_blk  = (cmd_t'(cmd) == CMD_ENCRYPT) || (cmd_t'(cmd) == CMD_DECRYPT);
    assign is_load = (cmd_t'(cmd) == CMD_LOAD) && (key_word_index < 6'(KEY_STORE_WORDS));
    assign enq     = acc && (is_blk || is_load);

    assign job_valid = (cnt_reg != '0);
    assign job       = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            fifo_reg[wp_reg] <= '{load: is_load,
                                  decrypt: (cmd_t'(cmd) == CMD_DECRYPT),
                                  key_addr: key_word_index[KEY_ADDR_W-1:0],
                                  key_data: key_word,
                                  block: {block_hi, block_lo}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (enq)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (job_take)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(enq) - (PTR_W+1)'(job_take);
        end
    end

endmodule

@@ rtl/core/aes_engine.sv @@
// ----------------------------------------------------------------------------
// aes_engine
// Round engine: applies key loads in queue order and runs one AES round per
// cycle from the key store, with a result register that holds the output
// block until it is popped.
// ----------------------------------------------------------------------------
module aes_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        key_length_mode,
    input  logic              job_valid,
    input  aes_pkg::job_t     job,
    output logic              job_take,
    output logic              empty,
    input  logic              pop,
    output logic [63:0]       result_hi,
    output logic [63:0]       result_lo
);
    import aes_pkg::*;

    // one round key per entry: one word written per load, one key read per round
    logic [127:0]          kmem [KEY_ROUNDS];
    logic [127:0]          rk_reg;
    logic [RK_ADDR_W-1:0]  wr_row;
    logic [1:0]            wr_lane;
    logic                  key_we;

    eng_state_t    state_reg, state_next;
    logic [3:0]    round_reg, round_next, nr;
    logic [3:0]    rd_round;
    logic          dec_reg, dec_next;
    logic [127:0]  st_reg, st_next;
    logic [127:0]  res_reg;
    logic          full_reg, full_next;
    logic          load_res;
    logic          first_reg, first_next;
    logic [127:0]  sb, sr, mc, ak;

    assign wr_row  = job.key_addr[KEY_ADDR_W-1:2];
    assign wr_lane = job.key_addr[1:0];

    always_comb
    begin
        case (mode_t'(key_length_mode))
            MODE_128: nr = 4'd10;
            MODE_192: nr = 4'd12;
            default:  nr = 4'd14;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            kmem[wr_row][127-32*int'(wr_lane) -: 32] <= job.key_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= kmem[rd_round];
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            sb[127-8*k -: 8] = dec_reg ? inv_sbox(st_reg[127-8*k -: 8])
                                       : sbox(st_reg[127-8*k -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (dec_reg)
                    sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+4-r)%4)) -: 8];
                else
                    sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
            end
        end
    end

    always_comb
    begin
        logic [127:0] x;
        x = dec_reg ? (sr ^ rk_reg) : sr;
        for (int c = 0; c < 4; c++)
        begin
            mc[127-32*c -: 32] = mix_col(x[127-32*c -: 32], dec_reg);
        end
        ak = dec_reg ? mc : (mc ^ rk_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        dec_next   = dec_reg;
        st_next    = st_reg;
        first_next = first_reg;
        full_next  = full_reg && !pop;
        job_take   = 1'b0;
        key_we     = 1'b0;
        load_res   = 1'b0;
        rd_round   = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    if (job.load)
                    begin
                        key_we = 1'b1;
                    end
                    else
                    begin
                        dec_next   = job.decrypt;
                        st_next    = job.block;
                        first_next = 1'b1;
                        round_next = job.decrypt ? nr : 4'd0;
                        rd_round   = round_next;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                if (first_reg)
                begin
                    st_next    = st_reg ^ rk_reg;
                    first_next = 1'b0;
                    round_next = dec_reg ? round_reg - 4'd1 : round_reg + 4'd1;
                    rd_round   = round_next;
                end
                else if ((!dec_reg && round_reg == nr) || (dec_reg && round_reg == 4'd0))
                begin
                    st_next    = sr ^ rk_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    st_next    = ak;
                    round_next = dec_reg ? round_reg - 4'd1 : round_reg + 4'd1;
                    rd_round   = round_next;
                end
            end
            ST_DONE:
            begin
                if (!full_reg || pop)
                begin
                    load_res   = 1'b1;
                    full_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            full_reg  <= 1'b0;
            round_reg <= '0;
            first_reg <= 1'b0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            round_reg <= round_next;
            first_reg <= first_next;
            dec_reg   <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (load_res)
        begin
            res_reg <= st_reg;
        end
    end

    assign empty     = !full_reg;
    assign result_hi = res_reg[127:64];
    assign result_lo = res_reg[63:0];

endmodule

@@ rtl/core/aes_block_encrypt_decrypt_top.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt_decrypt_top
// AES-128/192/256 cipher and inverse cipher over a loaded round-key store.
// ----------------------------------------------------------------------------
// Input channel: push/full. cmd 0 writes key_word to round-key word
// key_word_index; cmd 1 encrypts and cmd 2 decrypts {block_hi, block_lo};
// cmd 3 and loads beyond the store are dropped.
// Loads and blocks wait in order in a two-entry job queue ahead of the
// round engine; a load is applied as the engine takes it, for later blocks only.
// Result channel: empty/pop; result_hi/result_lo hold while empty is low.
// key_length_mode_we/key_length_mode write the round-count mode; the user
// must write it only while idle, as the block itself does not enforce this.
// The engine takes a job, adds the first round key, runs the Nr rounds and
// loads the result, and takes no new block until that result is loaded.
// A full result register stalls the engine; the queue then fills and full
// rises. Reset empties the queue and the result register and sets
// 128-bit mode; the key store holds nothing defined until loaded.
// ----------------------------------------------------------------------------
module aes_block_encrypt_decrypt_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_length_mode_we,
    input  logic [1:0]  key_length_mode,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [5:0]  key_word_index,
    input  logic [31:0] key_word,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);
    import aes_pkg::*;

    logic [1:0] mode_reg;
    logic       job_valid, job_take;
    job_t       job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_128;
        end
        else if (key_length_mode_we)
        begin
            mode_reg <= key_length_mode;
        end
    end

    aes_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .key_word_index(key_word_index), .key_word(key_word),
        .block_hi(block_hi), .block_lo(block_lo),
        .job_valid(job_valid), .job(job), .job_take(job_take)
    );

    aes_engine u_engine (
        .clk(clk), .rst_n(rst_n), .key_length_mode(mode_reg),
        .job_valid(job_valid), .job(job), .job_take(job_take), .empty(empty),
        .pop(pop), .result_hi(result_hi), .result_lo(result_lo)
    );

endmodule

@@ rtl/core/aes_checker.sv @@
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks of the AES block, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] result_hi,
    input logic [63:0] result_lo
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_hi) && $stable(result_lo)))
        else $error("result changed while waiting");
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown in reset");
    a_reset_full: assert property (@(posedge clk) !rst_n |-> !full)
        else $error("full in reset");
    a_known_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("unknown queue flags");
endmodule

bind aes_block_encrypt_decrypt_top aes_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .result_hi(result_hi), .result_lo(result_lo)
);
